/* rtl/tiny_language_lexer_top_assert.svh */
// Assertion macros for the lexer top level.
`ifndef TINY_LANGUAGE_LEXER_TOP_ASSERT_SVH
`define TINY_LANGUAGE_LEXER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");
// next-cycle implication
`define TLL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");
`else
`define TLL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tll_pkg.sv */
// Shared types, constants and character classes for the lexer.
`default_nettype none
package tll_pkg;

  localparam int MAX_LEXEME = 32;
  localparam int IDX_W      = $clog2(MAX_LEXEME);
  localparam int LEN_W      = $clog2(MAX_LEXEME + 1);
  localparam int NBANK      = 4;
  localparam int BANK_W     = $clog2(NBANK);
  localparam int CNT_W      = $clog2(NBANK + 1);
  localparam int MEM_AW     = BANK_W + IDX_W;
  localparam int MEM_DEPTH  = NBANK * (2 ** IDX_W);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int NWORD      = 8;
  localparam int WORD_MAX   = 6;

  localparam logic [4:0] KIND_WORD0  = 5'd9;
  localparam logic [4:0] KIND_ASSIGN = 5'd17;
  localparam logic [4:0] KIND_OTHER  = 5'd18;
  localparam logic [4:0] KIND_NUMBER = 5'd19;
  localparam logic [4:0] KIND_IDENT  = 5'd20;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;

  // reserved words, zero padded
  localparam logic [7:0] WORD_CHARS [NWORD][WORD_MAX] = '{
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00},  // then
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},  // else
    '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00},  // end
    '{8'h72, 8'h65, 8'h70, 8'h65, 8'h61, 8'h74},  // repeat
    '{8'h75, 8'h6E, 8'h74, 8'h69, 8'h6C, 8'h00},  // until
    '{8'h72, 8'h65, 8'h61, 8'h64, 8'h00, 8'h00},  // read
    '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00}   // write
  };
  localparam logic [LEN_W-1:0] WORD_LEN [NWORD] = '{
    LEN_W'(2), LEN_W'(4), LEN_W'(4), LEN_W'(3),
    LEN_W'(6), LEN_W'(5), LEN_W'(4), LEN_W'(5)
  };

  typedef enum logic [2:0] {
    M_START,
    M_COMMENT,
    M_NUM,
    M_ID,
    M_ASSIGN,
    M_SYMBOL
  } mode_t;

  // token descriptor passed from front to back
  typedef struct packed {
    logic [4:0]        kind;
    logic [LEN_W-1:0]  len;
    logic              trunc;
    logic              from_bank;
    logic [BANK_W-1:0] bank;
    logic [7:0]        ch;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic             pend;
  } fr_stat_t;

  function automatic logic is_dig(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_let(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h00};
  endfunction

  // {hit, symbol kind}
  function automatic logic [4:0] sym_lookup(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h2B:   r = 5'h10;  // +
      8'h2D:   r = 5'h11;  // -
      8'h2A:   r = 5'h12;  // *
      8'h2F:   r = 5'h13;  // /
      8'h3D:   r = 5'h14;  // =
      8'h3C:   r = 5'h15;  // <
      8'h28:   r = 5'h16;  // (
      8'h29:   r = 5'h17;  // )
      8'h3B:   r = 5'h18;  // ;
      default: r = 5'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/tll_front.sv */
// Front end: scanner automaton, lexeme bank writes and token descriptors.
`default_nettype none
module tll_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_char_in,
  output logic                    push_vld,
  output tll_pkg::tok_t           push_tok,
  input  wire logic               q_room2,
  input  wire logic               bank_done,
  output tll_pkg::mem_wr_t        mem_wr,
  output tll_pkg::fr_stat_t       stat
);

  tll_pkg::mode_t                    mode_r, mode_nxt;
  logic [tll_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic                              kw_r, kw_nxt;
  logic [3:0]                        sym_r, sym_nxt;
  logic                              ovf_r, ovf_nxt;
  logic [tll_pkg::NWORD-1:0]         match_r, match_nxt;
  logic [tll_pkg::BANK_W-1:0]        wbank_r, wbank_nxt;
  logic [tll_pkg::CNT_W-1:0]         used_r, used_nxt;
  logic                              pend_vld_r, pend_vld_nxt;
  tll_pkg::tok_t                     pend_tok_r, pend_tok_nxt;

  logic       accept;
  logic [7:0] c;
  logic       c_dig, c_let, c_ws, c_sym;
  logic [3:0] c_sym_code;
  logic [4:0] sym_hit;

  tll_pkg::mode_t sc_mode;
  logic           sc_app, sc_other;

  logic                       emit, do_sc, app_cur, handoff;
  logic [4:0]                 emit_kind, id_kind;
  logic [tll_pkg::LEN_W-1:0]  emit_len;
  logic [tll_pkg::BANK_W-1:0] sc_bank;
  tll_pkg::tok_t              desc1, inl_tok;

  assign c          = in_char_in;
  assign c_dig      = tll_pkg::is_dig(c);
  assign c_let      = tll_pkg::is_let(c);
  assign c_ws       = tll_pkg::is_ws(c);
  assign sym_hit    = tll_pkg::sym_lookup(c);
  assign c_sym      = sym_hit[4];
  assign c_sym_code = sym_hit[3:0];

  assign in_ready = !pend_vld_r && q_room2 &&
                    (used_r < tll_pkg::CNT_W'(tll_pkg::NBANK - 1));
  assign accept   = in_valid && in_ready;

  // what the start state does with the current character
  always_comb begin
    sc_mode  = tll_pkg::M_START;
    sc_app   = 1'b0;
    sc_other = 1'b0;
    if (c == tll_pkg::CH_LBRACE) begin
      sc_mode = tll_pkg::M_COMMENT;
    end else if (c == tll_pkg::CH_COLON) begin
      sc_app  = 1'b1;
      sc_mode = tll_pkg::M_ASSIGN;
    end else if (c_dig) begin
      sc_app  = 1'b1;
      sc_mode = tll_pkg::M_NUM;
    end else if (c_let) begin
      sc_app  = 1'b1;
      sc_mode = tll_pkg::M_ID;
    end else if (c_sym) begin
      sc_app  = 1'b1;
      sc_mode = tll_pkg::M_SYMBOL;
    end else if (!c_ws) begin
      sc_other = 1'b1;
    end
  end

  // reserved word test on the finished identifier
  always_comb begin
    id_kind = tll_pkg::KIND_IDENT;
    if (kw_r && !ovf_r) begin
      for (int k = tll_pkg::NWORD - 1; k >= 0; k--) begin
        if (match_r[k] && len_r == tll_pkg::WORD_LEN[k]) begin
          id_kind = tll_pkg::KIND_WORD0 + 5'(k);
        end
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    kw_nxt    = kw_r;
    sym_nxt   = sym_r;
    ovf_nxt   = ovf_r;
    match_nxt = match_r;
    wbank_nxt = wbank_r;
    emit      = 1'b0;
    emit_kind = tll_pkg::KIND_OTHER;
    emit_len  = len_r;
    do_sc     = 1'b0;
    app_cur   = 1'b0;
    mem_wr    = '0;

    case (mode_r)
      tll_pkg::M_COMMENT: begin
        if (c == tll_pkg::CH_RBRACE) mode_nxt = tll_pkg::M_START;
      end
      tll_pkg::M_NUM: begin
        if (c_dig) begin
          app_cur = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_kind = c_let ? tll_pkg::KIND_OTHER : tll_pkg::KIND_NUMBER;
          do_sc     = 1'b1;
        end
      end
      tll_pkg::M_ID: begin
        if (c_let || c_dig) begin
          app_cur = 1'b1;
          if (c_dig) kw_nxt = 1'b0;
        end else begin
          emit      = 1'b1;
          emit_kind = id_kind;
          do_sc     = 1'b1;
        end
      end
      tll_pkg::M_ASSIGN: begin
        if (c == tll_pkg::CH_EQ) begin
          app_cur   = 1'b1;
          emit      = 1'b1;
          emit_kind = tll_pkg::KIND_ASSIGN;
          emit_len  = len_r + tll_pkg::LEN_W'(1);
        end else begin
          emit      = 1'b1;
          emit_kind = tll_pkg::KIND_OTHER;
          do_sc     = 1'b1;
        end
      end
      tll_pkg::M_SYMBOL: begin
        emit      = 1'b1;
        emit_kind = {1'b0, sym_r};
        do_sc     = 1'b1;
      end
      default: begin
        do_sc = 1'b1;
      end
    endcase

    // append to the lexeme being built
    if (app_cur) begin
      if (len_r < tll_pkg::LEN_W'(tll_pkg::MAX_LEXEME)) begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = {wbank_r, len_r[tll_pkg::IDX_W-1:0]};
        len_nxt     = len_r + tll_pkg::LEN_W'(1);
        for (int k = 0; k < tll_pkg::NWORD; k++) begin
          match_nxt[k] = match_r[k] && (len_r < tll_pkg::LEN_W'(tll_pkg::WORD_MAX)) &&
                         (tll_pkg::WORD_CHARS[k][len_r[2:0]] == c);
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    sc_bank = emit ? wbank_r + tll_pkg::BANK_W'(1) : wbank_r;

    if (emit || do_sc) begin
      mode_nxt = tll_pkg::M_START;
      len_nxt  = '0;
      ovf_nxt  = 1'b0;
      kw_nxt   = 1'b0;
    end
    if (emit) wbank_nxt = sc_bank;

    if (do_sc) begin
      mode_nxt = sc_mode;
      if (sc_app) begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = {sc_bank, {tll_pkg::IDX_W{1'b0}}};
        len_nxt     = tll_pkg::LEN_W'(1);
      end
      if (c_let) begin
        kw_nxt = 1'b1;
        for (int k = 0; k < tll_pkg::NWORD; k++) begin
          match_nxt[k] = (tll_pkg::WORD_CHARS[k][0] == c);
        end
      end
      if (c_sym) sym_nxt = c_sym_code;
    end
    mem_wr.data = c;
    mem_wr.en   = mem_wr.en && accept;
  end

  assign handoff = accept && emit;

  always_comb begin
    desc1.kind      = emit_kind;
    desc1.len       = emit_len;
    desc1.trunc     = ovf_r;
    desc1.from_bank = 1'b1;
    desc1.bank      = wbank_r;
    desc1.ch        = 8'h00;

    inl_tok.kind      = tll_pkg::KIND_OTHER;
    inl_tok.len       = tll_pkg::LEN_W'(1);
    inl_tok.trunc     = 1'b0;
    inl_tok.from_bank = 1'b0;
    inl_tok.bank      = '0;
    inl_tok.ch        = c;

    pend_vld_nxt = 1'b0;
    pend_tok_nxt = pend_tok_r;
    push_vld     = 1'b0;
    push_tok     = desc1;
    if (pend_vld_r) begin
      push_vld = 1'b1;
      push_tok = pend_tok_r;
    end else if (accept && emit) begin
      push_vld = 1'b1;
      // a second token from the same beat is held in the pending register and pushed in the next cycle
      if (do_sc && sc_other) begin
        pend_vld_nxt = 1'b1;
        pend_tok_nxt = inl_tok;
      end
    end else if (accept && do_sc && sc_other) begin
      push_vld = 1'b1;
      push_tok = inl_tok;
    end

    used_nxt = used_r + tll_pkg::CNT_W'(handoff) - tll_pkg::CNT_W'(bank_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tll_pkg::M_START;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      kw_r       <= 1'b0;
      sym_r      <= '0;
      ovf_r      <= 1'b0;
      match_r    <= '0;
      wbank_r    <= '0;
      used_r     <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        len_r   <= len_nxt;
        kw_r    <= kw_nxt;
        sym_r   <= sym_nxt;
        ovf_r   <= ovf_nxt;
        match_r <= match_nxt;
        wbank_r <= wbank_nxt;
      end
      used_r     <= used_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_tok_r <= pend_tok_nxt;
  end

  assign stat.used = used_r;
  assign stat.pend = pend_vld_r;

endmodule
`default_nettype wire

/* rtl/tll_fifo.sv */
// Token descriptor queue between front and back end.
`default_nettype none
module tll_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_vld,
  input  wire tll_pkg::tok_t push_tok,
  input  wire logic          pop,
  output logic               head_vld,
  output tll_pkg::tok_t      head_tok,
  output logic               room2,
  output logic               full
);

  tll_pkg::tok_t               ent_r [tll_pkg::QDEPTH];
  logic [tll_pkg::QPTR_W-1:0]  wp_r, rp_r;
  logic [tll_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_push, do_pop;

  assign full     = (cnt_r == tll_pkg::QCNT_W'(tll_pkg::QDEPTH));
  assign room2    = (cnt_r <= tll_pkg::QCNT_W'(tll_pkg::QDEPTH - 2));
  assign head_vld = (cnt_r != '0);
  assign head_tok = ent_r[rp_r];
  assign do_push  = push_vld && !full;
  assign do_pop   = pop && head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + tll_pkg::QPTR_W'(1);
      if (do_pop)  rp_r <= rp_r + tll_pkg::QPTR_W'(1);
      cnt_r <= cnt_r + tll_pkg::QCNT_W'(do_push) - tll_pkg::QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_tok;
  end

endmodule
`default_nettype wire

/* rtl/tll_back.sv */
// Back end: lexeme banks and the result beat sequencer.
`default_nettype none
module tll_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_vld,
  input  wire tll_pkg::tok_t     head_tok,
  output logic                   pop,
  output logic                   bank_done,
  input  wire tll_pkg::mem_wr_t  mem_wr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [4:0]             out_token_kind,
  output logic [7:0]             out_lexeme_char,
  output logic [4:0]             out_char_index,
  output logic                   out_last,
  output logic                   out_truncated
);

  typedef struct packed {
    logic [4:0] kind;
    logic [4:0] idx;
    logic       last;
    logic       trunc;
    logic       inl;
    logic [7:0] ch;
  } beat_t;

  logic [7:0] mem [tll_pkg::MEM_DEPTH];
  logic [7:0] mem_q_r;

  logic                       act_r;
  tll_pkg::tok_t              cur_r;
  logic [tll_pkg::IDX_W-1:0]  idx_r;
  logic                       s1_vld_r;
  beat_t                      s1_r;
  logic                       out_vld_r;
  beat_t                      out_r;
  logic [7:0]                 out_ch_r;

  logic  s1_adv, issue, is_last;
  beat_t s1_in;

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_ready);
  assign issue     = act_r && (!s1_vld_r || s1_adv);
  assign is_last   = (tll_pkg::LEN_W'(idx_r) + tll_pkg::LEN_W'(1)) == cur_r.len;
  assign pop       = !act_r && head_vld;
  assign bank_done = issue && is_last && cur_r.from_bank;

  always_comb begin
    s1_in.kind  = cur_r.kind;
    s1_in.idx   = 5'(idx_r);
    s1_in.last  = is_last;
    s1_in.trunc = cur_r.trunc;
    s1_in.inl   = !cur_r.from_bank;
    s1_in.ch    = cur_r.ch;
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
    if (issue) mem_q_r <= mem[{cur_r.bank, idx_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        act_r <= 1'b1;
      end else if (issue && is_last) begin
        act_r <= 1'b0;
      end
      if (issue) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_tok;
      idx_r <= '0;
    end else if (issue) begin
      idx_r <= idx_r + tll_pkg::IDX_W'(1);
    end
    if (issue) s1_r <= s1_in;
    if (s1_adv) begin
      out_r    <= s1_r;
      out_ch_r <= s1_r.inl ? s1_r.ch : mem_q_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_token_kind  = out_r.kind;
  assign out_lexeme_char = out_ch_r;
  assign out_char_index  = out_r.idx;
  assign out_last        = out_r.last;
  assign out_truncated   = out_r.trunc;

endmodule
`default_nettype wire

/* rtl/tiny_language_lexer_top.sv */
// Top level of the character-stream lexer for the small teaching language.
`default_nettype none
`include "tiny_language_lexer_top_assert.svh"
// One source byte per input beat; each token comes out as a run of beats, one per
// lexeme character, with last on the final one. The input side takes a byte every
// cycle while the descriptor queue has room for two entries and a free lexeme bank
// is left (four banks of 32 bytes); a byte that both ends a token and forms a
// one-character OTHER token stalls input while the second token is pushed. The
// output side gives one beat per cycle while out_ready is high, and the sequencer
// loads each token from the queue before its first beat, so it sets the sustained
// token rate. Numbers, identifiers, symbols and a lone colon are sent only after the
// byte that follows them arrives; assign goes out on its '=' and a one-byte OTHER on
// its own byte. Lexemes past 32 bytes are cut and flagged truncated.
module tiny_language_lexer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_token_kind,
  output logic [7:0]      out_lexeme_char,
  output logic [4:0]      out_char_index,
  output logic            out_last,
  output logic            out_truncated
);

  logic              push_vld;
  tll_pkg::tok_t     push_tok;
  logic              q_room2, q_full, head_vld, pop, bank_done;
  tll_pkg::tok_t     head_tok;
  tll_pkg::mem_wr_t  mem_wr;
  tll_pkg::fr_stat_t fr_stat;

  tll_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .push_vld   (push_vld),
    .push_tok   (push_tok),
    .q_room2    (q_room2),
    .bank_done  (bank_done),
    .mem_wr     (mem_wr),
    .stat       (fr_stat)
  );

  tll_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_tok (push_tok),
    .pop      (pop),
    .head_vld (head_vld),
    .head_tok (head_tok),
    .room2    (q_room2),
    .full     (q_full)
  );

  tll_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld        (head_vld),
    .head_tok        (head_tok),
    .pop             (pop),
    .bank_done       (bank_done),
    .mem_wr          (mem_wr),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_lexeme_char (out_lexeme_char),
    .out_char_index  (out_char_index),
    .out_last        (out_last),
    .out_truncated   (out_truncated)
  );

  // the queue never overflows
  `TLL_ASSERT_IMP(a_push_room, clk, rst_n, push_vld, !q_full)
  // a bank is only released after it was handed off
  `TLL_ASSERT_IMP(a_bank_cnt, clk, rst_n, bank_done, fr_stat.used != '0)
  // a held second token drains by the next cycle
  `TLL_ASSERT_NXT(a_pend_drain, clk, rst_n, fr_stat.pend, !fr_stat.pend)
  // a cut lexeme always ends at the full buffer length
  `TLL_ASSERT_IMP(a_trunc_len, clk, rst_n, out_valid && out_last && out_truncated,
                  out_char_index == 5'(tll_pkg::MAX_LEXEME - 1))

endmodule
`default_nettype wire
